@@ rtl/lufd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lufd_pkg
// Shared types and constants for the lap unit frame decoder.
// ----------------------------------------------------------------------------
package lufd_pkg;

    localparam int MAX_FRAME = 32;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int IDX_W     = $clog2(MAX_FRAME);

    localparam logic [7:0] TERMINATOR = 8'd36;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] DRIVER_OFS = 8'd49;
    localparam logic [7:0] CTRL_LOW   = 8'd63;
    localparam logic [7:0] CTRL_HIGH  = 8'd127;
    localparam logic [7:0] OVF_SLOT   = 8'((MAX_FRAME + 1) % 256);

    localparam int LEN_STATUS  = 18;
    localparam int LEN_DRIVER  = 12;
    localparam int LEN_CTRL    = 6;
    localparam int LEN_PROGRAM = 4;

    localparam int TDATA_W = 160;
    localparam int PAD_W   = 5;

    typedef enum logic [2:0] {
        KIND_STATUS  = 3'd0,
        KIND_DRIVER  = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_CTRL    = 3'd3,
        KIND_PROGRAM = 3'd4,
        KIND_LEN_ERR = 3'd5
    } kind_t;

    // most significant field first, so slot_id lands in the lowest bits
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [8:0]       program_value_command;
        logic [5:0]       ctrl_chaos;
        logic [5:0]       ctrl_button;
        logic [23:0]      ctrl_speed;
        logic [5:0]       ctrl_valid;
        logic [5:0]       in_box;
        logic [1:0]       fuel_mode;
        logic [47:0]      fuel_levels;
        logic [7:0]       code_digit;
        logic [31:0]      timer_value;
        logic [7:0]       slot_id;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/lap_unit_frame_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lap_unit_frame_decoder_unit
// Collects received bytes up to a '$' terminator and decodes the frame.
// ----------------------------------------------------------------------------
// Output: a result word is registered from the accepted terminating byte and shows in the cycle after it.
// Throughput: one input word per cycle; input stalls only while a result
//   word waits in the output register and the sink is not ready.
// Reset: frame length and output valid clear asynchronously; the frame
//   store has no reset.
module lap_unit_frame_decoder_unit
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // rx_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // slot_id, timer_value, code_digit, fuel_levels, fuel_mode, in_box,
    // ctrl_valid, ctrl_speed, ctrl_button, ctrl_chaos, program_value_command
    output logic [lufd_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]        m_axis_tuser    // kind
);

    logic [7:0]                 store_reg [lufd_pkg::MAX_FRAME];
    logic [lufd_pkg::LEN_W-1:0] frame_length_reg, frame_length_next;
    logic                       valid_reg, valid_next;
    lufd_pkg::kind_t            kind_reg, kind_next;
    lufd_pkg::result_t          result_reg, result_next;

    logic       in_accept;
    logic       is_term;
    logic       full;
    logic       produce;
    logic       store_wr;
    logic [9:0] fm_v;
    logic [9:0] fm_adj;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_term       = (s_axis_tdata == lufd_pkg::TERMINATOR);
    assign full          = (frame_length_reg == lufd_pkg::LEN_W'(lufd_pkg::MAX_FRAME));
    assign store_wr      = in_accept && !is_term && !full;

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[frame_length_reg[lufd_pkg::IDX_W-1:0]] <= s_axis_tdata;
        end
    end

    // fuel mode: signed byte 11 less '0', less 12, 8 or 4 once when above 11, 7 or 3
    assign fm_v = {{2{store_reg[11][7]}}, store_reg[11]} - 10'd48;

    always_comb
    begin
        if ($signed(fm_v) > 10'sd11)
        begin
            fm_adj = fm_v - 10'd12;
        end
        else if ($signed(fm_v) > 10'sd7)
        begin
            fm_adj = fm_v - 10'd8;
        end
        else if ($signed(fm_v) > 10'sd3)
        begin
            fm_adj = fm_v - 10'd4;
        end
        else
        begin
            fm_adj = fm_v;
        end
    end

    always_comb
    begin
        frame_length_next = frame_length_reg;
        produce           = 1'b0;
        kind_next         = lufd_pkg::KIND_LEN_ERR;
        result_next       = '0;

        if (in_accept)
        begin
            if (!is_term)
            begin
                if (full)
                begin
                    frame_length_next   = '0;
                    produce             = 1'b1;
                    result_next.slot_id = lufd_pkg::OVF_SLOT;
                end
                else
                begin
                    frame_length_next = frame_length_reg + 1'b1;
                end
            end
            else
            begin
                frame_length_next = '0;
                produce           = (frame_length_reg > lufd_pkg::LEN_W'(1));
                if (frame_length_reg == lufd_pkg::LEN_W'(lufd_pkg::LEN_STATUS))
                begin
                    kind_next = lufd_pkg::KIND_STATUS;
                    for (int n = 0; n < 6; n++)
                    begin
                        result_next.fuel_levels[8*n +: 8] = store_reg[2+n] - lufd_pkg::ASCII_ZERO;
                    end
                    result_next.code_digit = store_reg[10] - lufd_pkg::ASCII_ZERO;
                    result_next.fuel_mode  = (fm_adj == 10'd1) ? 2'd1 :
                                             (fm_adj == 10'd2) ? 2'd2 : 2'd0;
                    result_next.in_box     = {store_reg[13][1:0], store_reg[12][3:0]};
                end
                else if (frame_length_reg == lufd_pkg::LEN_W'(lufd_pkg::LEN_DRIVER))
                begin
                    kind_next               = lufd_pkg::KIND_DRIVER;
                    result_next.slot_id     = store_reg[1] - lufd_pkg::DRIVER_OFS;
                    result_next.timer_value = {store_reg[3][3:0], store_reg[2][3:0],
                                               store_reg[5][3:0], store_reg[4][3:0],
                                               store_reg[7][3:0], store_reg[6][3:0],
                                               store_reg[9][3:0], store_reg[8][3:0]};
                    result_next.code_digit  = store_reg[10] - lufd_pkg::ASCII_ZERO;
                end
                else if (frame_length_reg == lufd_pkg::LEN_W'(lufd_pkg::LEN_CTRL))
                begin
                    if (store_reg[0] == lufd_pkg::ASCII_ZERO)
                    begin
                        kind_next = lufd_pkg::KIND_VERSION;
                    end
                    else
                    begin
                        kind_next = lufd_pkg::KIND_CTRL;
                        for (int n = 0; n < 6; n++)
                        begin
                            if (store_reg[n] > lufd_pkg::CTRL_LOW &&
                                store_reg[n] < lufd_pkg::CTRL_HIGH)
                            begin
                                result_next.ctrl_valid[n]        = 1'b1;
                                result_next.ctrl_speed[4*n +: 4] = store_reg[n][5:2];
                                result_next.ctrl_button[n]       = !store_reg[n][1];
                                result_next.ctrl_chaos[n]        = store_reg[n][0];
                            end
                        end
                    end
                end
                else if (frame_length_reg == lufd_pkg::LEN_W'(lufd_pkg::LEN_PROGRAM))
                begin
                    kind_next                         = lufd_pkg::KIND_PROGRAM;
                    result_next.slot_id               = {5'd0, store_reg[1][2:0]};
                    result_next.program_value_command = {store_reg[2][3:0], store_reg[3][4:0]};
                end
                else
                begin
                    result_next.slot_id = 8'(frame_length_reg);
                end
            end
        end

        if (produce)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= '0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            kind_reg   <= kind_next;
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = result_reg;
    assign m_axis_tuser  = kind_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_length_reg <= lufd_pkg::LEN_W'(lufd_pkg::MAX_FRAME))
        else $error("frame length beyond store");

    a_len_count: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr |=> frame_length_reg == $past(frame_length_reg) + 1'b1)
        else $error("stored byte not counted");

    a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_term) |=> frame_length_reg == '0)
        else $error("length not cleared after terminator");

    a_version_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == lufd_pkg::KIND_VERSION) |-> m_axis_tdata == '0)
        else $error("version word carries data");

    a_short_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_term && frame_length_reg <= lufd_pkg::LEN_W'(1)) |-> !produce)
        else $error("short frame produced a word");

endmodule
`default_nettype wire

@@ test/lap_unit_frame_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lap_unit_frame_decoder_unit_tb
// Sends '$'-terminated byte frames of every length class into the decoder:
// status, driver, version, controller and program frames, short frames, bad
// lengths and store overflow. Each decoded word is predicted from the bytes
// accepted and checked field by field. Idling and back-pressure vary over
// four phases.
// ----------------------------------------------------------------------------
module lap_unit_frame_decoder_unit_tb;

    localparam int BYTES_TOTAL = 360;
    localparam int STALL_LIMIT = 2000;

    typedef logic [7:0] byte_q_t [$];

    typedef struct {
        lufd_pkg::kind_t   kind;
        lufd_pkg::result_t data;
    } decoded_t;

    typedef enum {
        SHAPE_STATUS,
        SHAPE_DRIVER,
        SHAPE_VERSION,
        SHAPE_CTRL,
        SHAPE_PROGRAM,
        SHAPE_SHORT,
        SHAPE_ODD,
        SHAPE_OVERFLOW
    } shape_t;

    class frame_scoreboard;
        logic [7:0] store [lufd_pkg::MAX_FRAME];
        int         fill;
        decoded_t   expected_words [$];
        int         mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            decoded_t    w;
            int          len;
            int          v;
            logic [31:0] t;
            logic [7:0]  c;
            w.kind = lufd_pkg::KIND_LEN_ERR;
            w.data = '0;
            if (b != lufd_pkg::TERMINATOR)
            begin
                if (fill < lufd_pkg::MAX_FRAME)
                begin
                    store[fill] = b;
                    fill++;
                end
                else
                begin
                    // overflow: frame dropped, error word at once
                    fill = 0;
                    w.data.slot_id = lufd_pkg::OVF_SLOT;
                    expected_words.push_back(w);
                end
                return;
            end
            len = fill;
            fill = 0;
            if (len < 2)
                return;
            case (len)
                lufd_pkg::LEN_STATUS:
                begin
                    w.kind = lufd_pkg::KIND_STATUS;
                    for (int n = 0; n < 6; n++)
                        w.data.fuel_levels[8*n +: 8] = store[2+n] - lufd_pkg::ASCII_ZERO;
                    w.data.code_digit = store[10] - lufd_pkg::ASCII_ZERO;
                    v = int'($signed(store[11])) - 48;
                    if (v > 11)
                        v -= 12;
                    else if (v > 7)
                        v -= 8;
                    else if (v > 3)
                        v -= 4;
                    w.data.fuel_mode = (v == 1) ? 2'd1 : (v == 2) ? 2'd2 : 2'd0;
                    w.data.in_box = {store[13][1:0], store[12][3:0]};
                end
                lufd_pkg::LEN_DRIVER:
                begin
                    w.kind = lufd_pkg::KIND_DRIVER;
                    t = '0;
                    for (int i = 2; i < 10; i += 2)
                        t = {t[23:0], store[i+1][3:0], store[i][3:0]};
                    w.data.slot_id = store[1] - lufd_pkg::DRIVER_OFS;
                    w.data.timer_value = t;
                    w.data.code_digit = store[10] - lufd_pkg::ASCII_ZERO;
                end
                lufd_pkg::LEN_CTRL:
                begin
                    if (store[0] == lufd_pkg::ASCII_ZERO)
                        w.kind = lufd_pkg::KIND_VERSION;
                    else
                    begin
                        w.kind = lufd_pkg::KIND_CTRL;
                        for (int n = 0; n < 6; n++)
                        begin
                            c = store[n];
                            if (c > lufd_pkg::CTRL_LOW && c < lufd_pkg::CTRL_HIGH)
                            begin
                                w.data.ctrl_valid[n] = 1'b1;
                                w.data.ctrl_speed[4*n +: 4] = c[5:2];
                                w.data.ctrl_button[n] = ~c[1];
                                w.data.ctrl_chaos[n] = c[0];
                            end
                        end
                    end
                end
                lufd_pkg::LEN_PROGRAM:
                begin
                    w.kind = lufd_pkg::KIND_PROGRAM;
                    w.data.slot_id = {5'd0, store[1][2:0]};
                    w.data.program_value_command = {store[2][3:0], store[3][4:0]};
                end
                default:
                    w.data.slot_id = 8'(len);
            endcase
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [2:0] kind, lufd_pkg::result_t got);
            decoded_t w;
            if (expected_words.size() == 0)
            begin
                flag("unexpected word, kind", 0, kind);
                return;
            end
            w = expected_words.pop_front();
            if (kind != w.kind)
                flag("kind", w.kind, kind);
            if (got.slot_id != w.data.slot_id)
                flag("slot_id", w.data.slot_id, got.slot_id);
            if (got.timer_value != w.data.timer_value)
                flag("timer_value", w.data.timer_value, got.timer_value);
            if (got.code_digit != w.data.code_digit)
                flag("code_digit", w.data.code_digit, got.code_digit);
            if (got.fuel_levels != w.data.fuel_levels)
                flag("fuel_levels", w.data.fuel_levels, got.fuel_levels);
            if (got.fuel_mode != w.data.fuel_mode)
                flag("fuel_mode", w.data.fuel_mode, got.fuel_mode);
            if (got.in_box != w.data.in_box)
                flag("in_box", w.data.in_box, got.in_box);
            if (got.ctrl_valid != w.data.ctrl_valid)
                flag("ctrl_valid", w.data.ctrl_valid, got.ctrl_valid);
            if (got.ctrl_speed != w.data.ctrl_speed)
                flag("ctrl_speed", w.data.ctrl_speed, got.ctrl_speed);
            if (got.ctrl_button != w.data.ctrl_button)
                flag("ctrl_button", w.data.ctrl_button, got.ctrl_button);
            if (got.ctrl_chaos != w.data.ctrl_chaos)
                flag("ctrl_chaos", w.data.ctrl_chaos, got.ctrl_chaos);
            if (got.program_value_command != w.data.program_value_command)
                flag("program_value_command", w.data.program_value_command,
                     got.program_value_command);
            if (got.pad != w.data.pad)
                flag("padding", w.data.pad, got.pad);
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic [7:0]                   s_axis_tdata = '0;
    logic                         m_axis_tready = 1'b0;
    logic                         s_axis_tready;
    logic                         m_axis_tvalid;
    logic [lufd_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [2:0]                   m_axis_tuser;

    frame_scoreboard    frame_sb;
    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    int                 src_pct [4] = '{0, 69, 0, 19};
    int                 sink_pct [4] = '{0, 0, 69, 19};
    int                 bytes_sent = 0;
    int                 idle_cycles = 0;

    lap_unit_frame_decoder_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                frame_sb.check_word(m_axis_tuser, lufd_pkg::result_t'(m_axis_tdata));
            if (s_axis_tvalid && s_axis_tready)
                frame_sb.note_byte(s_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("lap_unit_frame_decoder_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == lufd_pkg::TERMINATOR);
        return b;
    endfunction

    function automatic logic [7:0] mixed_byte();
        if ($urandom_range(0, 1))
            return lufd_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
        return any_byte();
    endfunction

    function automatic shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return SHAPE_STATUS;
        if (r < 40)
            return SHAPE_DRIVER;
        if (r < 45)
            return SHAPE_VERSION;
        if (r < 60)
            return SHAPE_CTRL;
        if (r < 75)
            return SHAPE_PROGRAM;
        if (r < 80)
            return SHAPE_SHORT;
        if (r < 95)
            return SHAPE_ODD;
        return SHAPE_OVERFLOW;
    endfunction

    task automatic build_frame(input shape_t shape, output byte_q_t body);
        body = {};
        case (shape)
            SHAPE_STATUS:
            begin
                repeat (lufd_pkg::LEN_STATUS)
                    body.push_back(mixed_byte());
                // fuel mode byte: bias towards the reduction bands
                if ($urandom_range(0, 1))
                    body[11] = lufd_pkg::ASCII_ZERO + 8'($urandom_range(0, 15));
            end
            SHAPE_DRIVER:
                repeat (lufd_pkg::LEN_DRIVER)
                    body.push_back(mixed_byte());
            SHAPE_VERSION:
            begin
                body.push_back(lufd_pkg::ASCII_ZERO);
                repeat (lufd_pkg::LEN_CTRL - 1)
                    body.push_back(any_byte());
            end
            SHAPE_CTRL:
                repeat (lufd_pkg::LEN_CTRL)
                    body.push_back(($urandom_range(0, 9) < 7) ?
                                   8'($urandom_range(64, 126)) : any_byte());
            SHAPE_PROGRAM:
                repeat (lufd_pkg::LEN_PROGRAM)
                    body.push_back(mixed_byte());
            SHAPE_SHORT:
                repeat ($urandom_range(0, 1))
                    body.push_back(any_byte());
            SHAPE_ODD:
                repeat ($urandom_range(2, lufd_pkg::MAX_FRAME))
                    body.push_back(any_byte());
            default:
                repeat (lufd_pkg::MAX_FRAME + 1 + $urandom_range(0, 6))
                    body.push_back(any_byte());
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t body);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(lufd_pkg::TERMINATOR);
    endtask

    initial
    begin
        byte_q_t    body;
        int         base;
        logic [7:0] mode_bytes [6];
        mode_bytes = '{8'h31, 8'h32, 8'h3D, 8'h3F, 8'h41, 8'hC8};
        frame_sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty and single-byte frames
        body = {};
        send_frame(body);
        body = '{8'hFF};
        send_frame(body);

        // status: fuel mode bytes below 4, above 11 and negative, plus field extremes
        foreach (mode_bytes[m])
        begin
            build_frame(SHAPE_STATUS, body);
            body[11] = mode_bytes[m];
            if (m == 0)
            begin
                body[2] = 8'h00;
                body[3] = 8'hFF;
                body[12] = 8'hFF;
                body[13] = 8'h00;
            end
            send_frame(body);
        end

        build_frame(SHAPE_DRIVER, body);
        body[1] = 8'h00;
        send_frame(body);
        build_frame(SHAPE_DRIVER, body);
        body[1] = 8'hFF;
        for (int i = 2; i < 11; i++)
            body[i] = 8'hFF;
        send_frame(body);

        build_frame(SHAPE_VERSION, body);
        send_frame(body);

        // controller range edges, inside and outside
        body = '{8'd64, 8'd126, 8'd63, 8'd127, 8'd0, 8'd255};
        send_frame(body);
        build_frame(SHAPE_CTRL, body);
        send_frame(body);

        build_frame(SHAPE_PROGRAM, body);
        body[2] = 8'hFF;
        body[3] = 8'hFF;
        send_frame(body);
        build_frame(SHAPE_PROGRAM, body);
        send_frame(body);

        // bad lengths, a full store, then overflow
        body = '{8'h41, 8'h42};
        send_frame(body);
        body = {};
        repeat (lufd_pkg::LEN_STATUS + 1)
            body.push_back(any_byte());
        send_frame(body);
        body = {};
        repeat (lufd_pkg::MAX_FRAME)
            body.push_back(any_byte());
        send_frame(body);
        build_frame(SHAPE_OVERFLOW, body);
        send_frame(body);

        base = bytes_sent;
        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            while (bytes_sent < base + BYTES_TOTAL * (p + 1) / 4)
            begin
                build_frame(pick_shape(), body);
                send_frame(body);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (frame_sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (frame_sb.mismatches == 0)
            $display("lap_unit_frame_decoder_unit_tb: done, clean");
        else
            $display("lap_unit_frame_decoder_unit_tb: done, errors");
        $finish;
    end

endmodule
